FILE: hdl/sus_pkg.sv
// sus_pkg: shared constants, status codes and control types for the sorted set block
// no dependencies; imported by every module of the block
package sus_pkg;

    localparam int CAPACITY_DEF   = 32;
    localparam int VALUE_BITS_DEF = 8;
    localparam int FIELD_BITS     = 8;

    // result status codes
    localparam logic [1:0] STATUS_DUP   = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_EVICT = 2'd2;
    localparam logic [1:0] STATUS_DUMP  = 2'd3;

    // request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DUMP   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_WRITE,
        S_DUMP
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CHECK,
        CELL_INSERT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

endpackage

FILE: hdl/sus_cell.sv
// sus_cell: one table slot with its compare flags and neighbor handoff
// depends on sus_pkg
module sus_cell #(
    parameter int VALUE_BITS = sus_pkg::VALUE_BITS_DEF,
    parameter bit IS_LOW     = 1'b0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sus_pkg::cell_ctrl_t    ctrl,
    input  logic [VALUE_BITS-1:0]  ins_value,
    input  logic [VALUE_BITS-1:0]  nbr_entry,
    input  logic                   nbr_lt,
    output logic [VALUE_BITS-1:0]  entry,
    output logic                   lt,
    output logic                   match
);
    import sus_pkg::*;

    logic [VALUE_BITS-1:0] entry_reg;
    logic [VALUE_BITS-1:0] entry_next;
    logic                  lt_reg;
    logic                  lt_next;
    logic                  match_reg;
    logic                  match_next;

    always_comb
    begin
        entry_next = entry_reg;
        lt_next    = lt_reg;
        match_next = match_reg;
        case (ctrl.op)
            CELL_CHECK:
            begin
                lt_next    = entry_reg < ins_value;
                match_next = entry_reg == ins_value;
            end
            CELL_INSERT:
            begin
                // entries below the new value slide down one slot
                if (nbr_lt)
                begin
                    entry_next = nbr_entry;
                end
                else if (lt_reg || IS_LOW)
                begin
                    entry_next = ins_value;
                end
            end
            CELL_ROTATE:
            begin
                entry_next = nbr_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            lt_reg    <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            entry_reg <= entry_next;
            lt_reg    <= lt_next;
            match_reg <= match_next;
        end
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign match = match_reg;

endmodule

FILE: hdl/sorted_unique_set_insert.sv
// sorted_unique_set_insert: ascending table of distinct nonzero values in a row of cells
// insert: accepted, compared, then written with its result registered once the output is free;
//   next item accepted only once back in idle (compare, write, return to idle)
// dump: CAPACITY results, one per cycle while not stalled, by rotating the row of cells
// reset clears every slot to empty and the block to idle; depends on sus_pkg and sus_cell
module sorted_unique_set_insert #(
    parameter int CAPACITY   = sus_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = sus_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [sus_pkg::FIELD_BITS-1:0] value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [sus_pkg::FIELD_BITS-1:0] element,
    output logic                          last
);
    import sus_pkg::*;

    localparam int CW = $clog2(CAPACITY);

    state_t                state_reg;
    state_t                state_next;
    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] val_next;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    logic [1:0]            res_status_reg;
    logic [1:0]            res_status_next;
    logic [FIELD_BITS-1:0] res_elem_reg;
    logic [FIELD_BITS-1:0] res_elem_next;

    logic [VALUE_BITS-1:0] entries [CAPACITY];
    logic [CAPACITY-1:0]   lt_v;
    logic [CAPACITY-1:0]   match_v;
    cell_ctrl_t            ctrl;

    logic in_fire;
    logic out_fire;
    logic res_free;
    logic dup;
    logic dump_beat;

    assign in_fire    = in_valid && !in_stall;
    assign out_fire   = out_valid && !out_stall;
    assign res_free   = !res_valid_reg || out_fire;
    assign dup        = (val_reg == '0) || (|match_v);
    assign dump_beat  = (state_reg == S_DUMP) && !res_valid_reg && !out_stall;

    // cell row: each slot reads its upper neighbor, the top slot wraps to slot 0 for dumps
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_BITS-1:0] nbr_e;
        logic                  nbr_l;
        if (i == CAPACITY - 1)
        begin : g_top
            assign nbr_e = entries[0];
            assign nbr_l = 1'b0;
        end
        else
        begin : g_mid
            assign nbr_e = entries[i+1];
            assign nbr_l = lt_v[i+1];
        end
        sus_cell #(
            .VALUE_BITS (VALUE_BITS),
            .IS_LOW     (i == 0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .ins_value (val_reg),
            .nbr_entry (nbr_e),
            .nbr_lt    (nbr_l),
            .entry     (entries[i]),
            .lt        (lt_v[i]),
            .match     (match_v[i])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (req_type == REQ_DUMP) ? S_DUMP : S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (dump_beat && (cnt_reg == CW'(CAPACITY - 1)))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        in_stall        = 1'b1;
        ctrl.op         = CELL_HOLD;
        val_next        = val_reg;
        cnt_next        = cnt_reg;
        res_valid_next  = res_valid_reg && out_stall;
        res_status_next = res_status_reg;
        res_elem_next   = res_elem_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_fire)
                begin
                    val_next = VALUE_BITS'(value);
                    cnt_next = '0;
                end
            end
            S_CHECK:
            begin
                ctrl.op = CELL_CHECK;
            end
            S_WRITE:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_elem_next  = FIELD_BITS'(val_reg);
                    if (dup)
                    begin
                        res_status_next = STATUS_DUP;
                    end
                    else
                    begin
                        res_status_next = (entries[0] == '0) ? STATUS_EMPTY : STATUS_EVICT;
                        ctrl.op         = CELL_INSERT;
                    end
                end
            end
            S_DUMP:
            begin
                if (dump_beat)
                begin
                    ctrl.op  = CELL_ROTATE;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_elem_reg   <= res_elem_next;
    end

    // a pending insert result goes out before any dump entry
    assign out_valid = res_valid_reg || (state_reg == S_DUMP);
    assign status    = res_valid_reg ? res_status_reg : STATUS_DUMP;
    assign element   = res_valid_reg ? res_elem_reg : FIELD_BITS'(entries[0]);
    assign last      = res_valid_reg || (cnt_reg == CW'(CAPACITY - 1));

endmodule

FILE: hdl/sus_checker.sv
// sus_checker: port-level assertions for sorted_unique_set_insert, bound to the top level
// depends on sus_pkg
module sus_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           req_type,
    input logic [sus_pkg::FIELD_BITS-1:0] value,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [1:0]                     status,
    input logic [sus_pkg::FIELD_BITS-1:0] element,
    input logic                           last
);
    import sus_pkg::*;

    // an insert answers with a single item
    a_insert_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_DUMP) |-> last)
        else $error("insert result without last");

    // a dump keeps streaming until its last entry is taken
    a_dump_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && (status == STATUS_DUMP) && !last
        |=> out_valid && (status == STATUS_DUMP))
        else $error("dump stream broken");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall
        |=> out_valid && $stable(status) && $stable(element) && $stable(last))
        else $error("stalled result changed");

endmodule

bind sorted_unique_set_insert sus_checker u_sus_checker (.*);

FILE: dv/testbench.sv
// testbench for sorted_unique_set_insert: directed table then random inserts and dumps,
// every result checked against a sorted-set predictor kept in step with accepted items
// depends on sus_pkg and the block's rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sus_pkg::*;

    localparam int SLOTS          = CAPACITY_DEF;
    localparam int VW             = FIELD_BITS;
    localparam int IDLE_PCT       = 38;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RAND_ITEMS     = 420;
    localparam int TAIL_CYCLES    = 20;
    localparam int N_ROWS         = 18;

    typedef struct packed {
        logic [1:0]    status;
        logic [VW-1:0] element;
        logic          last;
    } set_result_t;

    // kind, value, status typed in or not, typed status
    typedef struct packed {
        logic          kind;
        logic [VW-1:0] val;
        logic          typed;
        logic [1:0]    st;
    } stim_row_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic          req_type;
    logic [VW-1:0] value;
    logic          out_valid;
    logic          out_stall;
    logic [1:0]    status;
    logic [VW-1:0] element;
    logic          last;

    logic [VW-1:0] set_slots [SLOTS];
    set_result_t   pending_results [$];
    set_result_t   oldest;

    bit calm;
    bit hold_req;
    int errors = 0;
    int idle_cycles = 0;
    int n_results = 0;
    int n_empty_ins;
    int n_evict_ins;
    int n_dup_ins;
    int n_dumps;

    stim_row_t directed_rows [N_ROWS] = '{
        '{REQ_DUMP,   8'h00, 1'b0, STATUS_DUMP},   // empty table after reset
        '{REQ_INSERT, 8'hFF, 1'b1, STATUS_EMPTY},
        '{REQ_INSERT, 8'hFF, 1'b1, STATUS_DUP},
        '{REQ_INSERT, 8'h00, 1'b1, STATUS_DUP},    // zero never enters the table
        '{REQ_INSERT, 8'h01, 1'b1, STATUS_EMPTY},
        '{REQ_INSERT, 8'h01, 1'b1, STATUS_DUP},
        '{REQ_INSERT, 8'h80, 1'b1, STATUS_EMPTY},
        '{REQ_INSERT, 8'h55, 1'b1, STATUS_EMPTY},
        '{REQ_INSERT, 8'hAA, 1'b1, STATUS_EMPTY},
        '{REQ_INSERT, 8'h7F, 1'b1, STATUS_EMPTY},
        '{REQ_INSERT, 8'h02, 1'b1, STATUS_EMPTY},
        '{REQ_INSERT, 8'hFE, 1'b1, STATUS_EMPTY},
        '{REQ_DUMP,   8'hFF, 1'b0, STATUS_DUMP},   // value ignored on dump
        '{REQ_INSERT, 8'hAA, 1'b1, STATUS_DUP},
        '{REQ_INSERT, 8'h00, 1'b1, STATUS_DUP},
        '{REQ_DUMP,   8'h5A, 1'b0, STATUS_DUMP},
        '{REQ_INSERT, 8'h0F, 1'b1, STATUS_EMPTY},
        '{REQ_INSERT, 8'hF0, 1'b1, STATUS_EMPTY}
    };

    sorted_unique_set_insert u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .element   (element),
        .last      (last)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // update the set and queue the results one accepted item causes
    function automatic void apply_request(input logic kind, input logic [VW-1:0] val,
                                          input logic typed, input logic [1:0] st);
        set_result_t r;
        bit          present;
        int          i;
        if (kind == REQ_DUMP)
        begin
            n_dumps++;
            for (i = 0; i < SLOTS; i++)
            begin
                r.status  = STATUS_DUMP;
                r.element = set_slots[i];
                r.last    = (i == SLOTS - 1);
                pending_results.push_back(r);
            end
        end
        else
        begin
            present = 1'b0;
            for (i = 0; i < SLOTS; i++)
                if (set_slots[i] == val)
                    present = 1'b1;
            r.element = val;
            r.last    = 1'b1;
            if (val == '0 || present)
            begin
                r.status = STATUS_DUP;
                n_dup_ins++;
            end
            else
            begin
                r.status = (set_slots[0] == '0) ? STATUS_EMPTY : STATUS_EVICT;
                if (r.status == STATUS_EMPTY)
                    n_empty_ins++;
                else
                    n_evict_ins++;
                // overwrite the lowest slot and bubble the new value up
                i = 1;
                while (i < SLOTS && set_slots[i] < val)
                begin
                    set_slots[i-1] = set_slots[i];
                    i++;
                end
                set_slots[i-1] = val;
            end
            if (typed)
                r.status = st;
            pending_results.push_back(r);
        end
    endfunction

    // mix of present values, extremes, small values and uniform values
    function automatic logic [VW-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 30)
            return set_slots[$urandom_range(SLOTS-1)];
        else if (sel < 34)
            return '0;
        else if (sel < 38)
            return '1;
        else if (sel < 42)
            return 8'h01;
        else if (sel < 52)
            return VW'($urandom_range(15, 1));
        else
            return VW'($urandom_range(255, 1));
    endfunction

    task automatic offer(input logic kind, input logic [VW-1:0] val,
                         input logic typed, input logic [1:0] st);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        value    <= val;
        do
            @(posedge clk);
        while (in_stall);
        apply_request(kind, val, typed, st);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 10)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected item status=%0d element=%0d last=%0d",
                                          status, element, last));
            else
            begin
                oldest = pending_results.pop_front();
                if (status !== oldest.status || element !== oldest.element
                    || last !== oldest.last)
                    report_mismatch($sformatf(
                        "exp status=%0d element=%0d last=%0d got status=%0d element=%0d last=%0d",
                        oldest.status, oldest.element, oldest.last, status, element, last));
            end
        end
    end

    // watchdog on cycles with no item accepted on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d cycles with no item accepted", idle_cycles);
                $display("FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver side stall
    initial
    begin
        int k;
        bit held;
        held = 1'b0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !held)
            begin
                held = 1'b1;
                // long hold so the block backs up onto its input
                for (k = 0; k < HOLD_CYCLES; k++)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            else
            begin
                out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
                @(posedge clk);
            end
        end
    end

    // sender side and end of run
    initial
    begin
        int            n;
        logic          kind;
        logic [VW-1:0] val;
        n_empty_ins = 0;
        n_evict_ins = 0;
        n_dup_ins   = 0;
        n_dumps     = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        for (n = 0; n < SLOTS; n++)
            set_slots[n] = '0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        req_type <= REQ_INSERT;
        value    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < N_ROWS; n++)
            offer(directed_rows[n].kind, directed_rows[n].val,
                  directed_rows[n].typed, directed_rows[n].st);

        for (n = 0; n < RAND_ITEMS; n++)
        begin
            calm = (n >= 150 && n < 230);
            if (n == 60)
                hold_req = 1'b1;
            if (n == 300)
                wait_drained();
            kind = ($urandom_range(99) < 8) ? REQ_DUMP : REQ_INSERT;
            val  = (kind == REQ_DUMP) ? VW'($urandom_range(255)) : pick_value();
            offer(kind, val, 1'b0, STATUS_DUP);
        end
        calm = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d items: %0d inserts into empty slots, %0d with eviction, %0d duplicates",
                 N_ROWS + RAND_ITEMS, n_empty_ins, n_evict_ins, n_dup_ins);
        $display("%0d full dumps, %0d results checked, %0d mismatches",
                 n_dumps, n_results, errors);
        if (errors == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/sus_pkg.sv
hdl/sus_cell.sv
hdl/sorted_unique_set_insert.sv
hdl/sus_checker.sv
dv/testbench.sv
